// File: design/battery_thermal_charge_limiter_defines.svh
// Assertion macros for the battery thermal charge limiter
`ifndef BATTERY_THERMAL_CHARGE_LIMITER_DEFINES_SVH
`define BATTERY_THERMAL_CHARGE_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BTCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btcl same-cycle check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define BTCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btcl next-cycle check failed");

`endif

// File: design/btcl_pkg.sv
package btcl_pkg;

	localparam int KELVIN_OFFSET_DK = 2731;

	localparam logic [15:0] TK_1C  = 16'(KELVIN_OFFSET_DK + 10 * 1);
	localparam logic [15:0] TK_5C  = 16'(KELVIN_OFFSET_DK + 10 * 5);
	localparam logic [15:0] TK_10C = 16'(KELVIN_OFFSET_DK + 10 * 10);
	localparam logic [15:0] TK_15C = 16'(KELVIN_OFFSET_DK + 10 * 15);
	localparam logic [15:0] TK_20C = 16'(KELVIN_OFFSET_DK + 10 * 20);
	localparam logic [15:0] TK_43C = 16'(KELVIN_OFFSET_DK + 10 * 43);
	localparam logic [15:0] TK_45C = 16'(KELVIN_OFFSET_DK + 10 * 45);
	localparam logic [15:0] TK_50C = 16'(KELVIN_OFFSET_DK + 10 * 50);

	localparam logic [1:0] CHG_IDLE      = 2'd0;
	localparam logic [1:0] CHG_CHARGE    = 2'd1;
	localparam logic [1:0] CHG_DISCHARGE = 2'd2;

	localparam logic [6:0] MODE_NONE    = 7'h00;
	localparam logic [6:0] MODE_TRIG_5  = 7'h01;
	localparam logic [6:0] MODE_TRIG_15 = 7'h02;
	localparam logic [6:0] MODE_TRIG_45 = 7'h04;
	localparam logic [6:0] MODE_TRIG_50 = 7'h08;
	localparam logic [6:0] MODE_REC_10  = 7'h10;
	localparam logic [6:0] MODE_REC_20  = 7'h20;
	localparam logic [6:0] MODE_REC_43  = 7'h40;
	localparam logic [6:0] MODE_MASK    = 7'h7F;

	localparam logic [2:0] CFG_TRIGGER_VOLTAGE  = 3'd0;
	localparam logic [2:0] CFG_REDUCED_VOLTAGE  = 3'd1;
	localparam logic [2:0] CFG_LOW_CURRENT      = 3'd2;
	localparam logic [2:0] CFG_HOT_CURRENT      = 3'd3;
	localparam logic [2:0] CFG_RECOVERY_CURRENT = 3'd4;
	localparam logic [2:0] CFG_VOLTAGE_BUMP     = 3'd5;

	localparam logic [15:0] RST_TRIGGER_VOLTAGE  = 16'd8300;
	localparam logic [15:0] RST_REDUCED_VOLTAGE  = 16'd8300;
	localparam logic [15:0] RST_LOW_CURRENT      = 16'd1464;
	localparam logic [15:0] RST_HOT_CURRENT      = 16'd1647;
	localparam logic [15:0] RST_RECOVERY_CURRENT = 16'd3294;
	localparam logic [9:0]  RST_VOLTAGE_BUMP     = 10'd100;

	typedef struct packed {
		logic [15:0] trigger_voltage_mv;
		logic [15:0] reduced_voltage_mv;
		logic [15:0] low_current_ma;
		logic [15:0] hot_current_ma;
		logic [15:0] recovery_current_ma;
		logic [9:0]  voltage_bump_mv;
	} btcl_cfg_t;

	typedef struct packed {
		logic       stop;
		logic       ac_known;
		logic       last_ac;
		logic [6:0] mode;
	} btcl_state_t;

	typedef struct packed {
		logic [15:0] temp_deci_kelvin;
		logic [15:0] batt_voltage_mv;
		logic        ac_present;
		logic [1:0]  charge_state_in;
		logic [15:0] req_voltage_in;
		logic [15:0] req_current_in;
		logic        want_charge_in;
	} btcl_item_t;

	typedef struct packed {
		logic [15:0] req_voltage_out;
		logic [15:0] req_current_out;
		logic [1:0]  charge_state_out;
		logic        want_charge_out;
	} btcl_result_t;

endpackage

// File: design/btcl_rule.sv
module btcl_rule (
	input  btcl_pkg::btcl_cfg_t    cfg,
	input  btcl_pkg::btcl_state_t  state,
	input  btcl_pkg::btcl_item_t   item,
	output btcl_pkg::btcl_result_t res,
	output btcl_pkg::btcl_state_t  state_next
);
	import btcl_pkg::*;

	logic        ge1, ge5, ge10, ge15, ge20, ge43, ge45, ge50;
	logic        ac_change;
	logic        stop_pre;
	logic [16:0] bump_sum;

	assign ge1  = item.temp_deci_kelvin >= TK_1C;
	assign ge5  = item.temp_deci_kelvin >= TK_5C;
	assign ge10 = item.temp_deci_kelvin >= TK_10C;
	assign ge15 = item.temp_deci_kelvin >= TK_15C;
	assign ge20 = item.temp_deci_kelvin >= TK_20C;
	assign ge43 = item.temp_deci_kelvin >= TK_43C;
	assign ge45 = item.temp_deci_kelvin >= TK_45C;
	assign ge50 = item.temp_deci_kelvin >= TK_50C;

	assign ac_change = !state.ac_known || (item.ac_present != state.last_ac);
	assign stop_pre  = state.stop || (ac_change && item.ac_present && (!ge1 || ge45));
	assign bump_sum  = {1'b0, item.req_voltage_in} + {7'b0, cfg.voltage_bump_mv};

	always_comb begin
		logic [6:0]  mode;
		logic [15:0] volt;
		logic [15:0] cur;
		logic [1:0]  st;
		logic        want;

		mode = state.mode;
		volt = item.req_voltage_in;
		cur  = item.req_current_in;
		st   = item.charge_state_in;
		want = item.want_charge_in;

		if (stop_pre) begin
			volt = '0;
			cur  = '0;
			want = 1'b0;
			if (st != CHG_DISCHARGE) begin
				st = CHG_IDLE;
			end
		end

		// a charging sample here implies the latch was and stays clear
		if (st == CHG_CHARGE) begin
			if (item.batt_voltage_mv < cfg.trigger_voltage_mv) begin
				if (!ge5) begin
					mode = MODE_TRIG_5;
				end else if (!ge15) begin
					mode = MODE_TRIG_15;
				end
				if (ge50) begin
					mode = MODE_TRIG_50;
				end else if (ge45 && ((mode & MODE_TRIG_50) == MODE_NONE)) begin
					mode = MODE_TRIG_45;
				end
			end

			if (mode != MODE_NONE) begin
				if (ge10 && !ge20) begin
					mode = MODE_REC_10;
				end else if (ge20 && !ge43) begin
					mode = MODE_REC_20;
				end else if (ge43 && !ge45) begin
					mode = MODE_REC_43;
				end
			end else begin
				volt = bump_sum[16] ? 16'hFFFF : bump_sum[15:0];
			end

			if ((mode & MODE_TRIG_5) != MODE_NONE) begin
				volt = cfg.reduced_voltage_mv;
				cur  = cfg.low_current_ma;
			end else if ((mode & MODE_TRIG_15) != MODE_NONE) begin
				cur = cfg.low_current_ma;
			end else if ((mode & MODE_TRIG_45) != MODE_NONE) begin
				volt = cfg.reduced_voltage_mv;
				cur  = cfg.hot_current_ma;
			end else if ((mode & MODE_TRIG_50) != MODE_NONE) begin
				volt = '0;
				cur  = '0;
				want = 1'b0;
				st   = CHG_IDLE;
			end else if ((mode & MODE_REC_10) != MODE_NONE) begin
				cur = cfg.low_current_ma;
			end else if ((mode & (MODE_REC_20 | MODE_REC_43)) != MODE_NONE) begin
				cur = cfg.recovery_current_ma;
			end
		end else begin
			mode = MODE_NONE;
		end

		res.req_voltage_out  = volt;
		res.req_current_out  = cur;
		res.charge_state_out = st;
		res.want_charge_out  = want;

		state_next.stop     = (ge1 && !ge45) ? 1'b0 : stop_pre;
		state_next.ac_known = 1'b1;
		state_next.last_ac  = ac_change ? item.ac_present : state.last_ac;
		state_next.mode     = mode & MODE_MASK;
	end

endmodule

// File: design/battery_thermal_charge_limiter.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    temperature, battery voltage, adapter, state, request
// out      out_valid / out_ready  overridden voltage, current, state, want-charge
// cfg      cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (16 bits)
//
// Input and result registers; one sample per cycle while out_ready is high.
// The input register feeds the limiter rule, which updates the thermal state and
// loads the result register in the same edge.
// Reset restores configuration defaults, sets the stop latch and all mode bits.
// A stalled result holds the result register; the input register fills only if empty.
module battery_thermal_charge_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] temp_deci_kelvin,
	input  logic [15:0] batt_voltage_mv,
	input  logic        ac_present,
	input  logic [1:0]  charge_state_in,
	input  logic [15:0] req_voltage_in,
	input  logic [15:0] req_current_in,
	input  logic        want_charge_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] req_voltage_out,
	output logic [15:0] req_current_out,
	output logic [1:0]  charge_state_out,
	output logic        want_charge_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import btcl_pkg::*;

	`include "battery_thermal_charge_limiter_defines.svh"

	btcl_cfg_t    cfg_q;
	btcl_state_t  state_q;
	btcl_state_t  state_next;
	btcl_item_t   item_s1;
	logic         valid_s1;
	btcl_result_t res;
	btcl_result_t res_s2;
	logic         valid_s2;
	logic         advance;
	logic         fire;
	logic         band_s1;
	logic         held_stop;
	logic         zero_out;

	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_voltage_mv  <= RST_TRIGGER_VOLTAGE;
			cfg_q.reduced_voltage_mv  <= RST_REDUCED_VOLTAGE;
			cfg_q.low_current_ma      <= RST_LOW_CURRENT;
			cfg_q.hot_current_ma      <= RST_HOT_CURRENT;
			cfg_q.recovery_current_ma <= RST_RECOVERY_CURRENT;
			cfg_q.voltage_bump_mv     <= RST_VOLTAGE_BUMP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TRIGGER_VOLTAGE:  cfg_q.trigger_voltage_mv  <= cfg_data;
				CFG_REDUCED_VOLTAGE:  cfg_q.reduced_voltage_mv  <= cfg_data;
				CFG_LOW_CURRENT:      cfg_q.low_current_ma      <= cfg_data;
				CFG_HOT_CURRENT:      cfg_q.hot_current_ma      <= cfg_data;
				CFG_RECOVERY_CURRENT: cfg_q.recovery_current_ma <= cfg_data;
				CFG_VOLTAGE_BUMP:     cfg_q.voltage_bump_mv     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.temp_deci_kelvin <= temp_deci_kelvin;
			item_s1.batt_voltage_mv  <= batt_voltage_mv;
			item_s1.ac_present       <= ac_present;
			item_s1.charge_state_in  <= charge_state_in;
			item_s1.req_voltage_in   <= req_voltage_in;
			item_s1.req_current_in   <= req_current_in;
			item_s1.want_charge_in   <= want_charge_in;
		end
	end

	btcl_rule u_rule (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.res        (res),
		.state_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stop     <= 1'b1;
			state_q.ac_known <= 1'b0;
			state_q.last_ac  <= 1'b0;
			state_q.mode     <= MODE_MASK;
			valid_s2         <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign req_voltage_out  = res_s2.req_voltage_out;
	assign req_current_out  = res_s2.req_current_out;
	assign charge_state_out = res_s2.charge_state_out;
	assign want_charge_out  = res_s2.want_charge_out;

	assign fire      = advance && valid_s1;
	assign band_s1   = (item_s1.temp_deci_kelvin >= TK_1C) && (item_s1.temp_deci_kelvin < TK_45C);
	assign held_stop = state_q.stop && state_q.ac_known && (item_s1.ac_present == state_q.last_ac);
	assign zero_out  = out_valid && (req_current_out == 16'd0) && (req_voltage_out == 16'd0)
		&& !want_charge_out;

	`BTCL_ASSERT_NOW(a_mode_shape, 1'b1, $onehot0(state_q.mode) || (state_q.mode == MODE_MASK))
	`BTCL_ASSERT_NEXT(a_band_clears_stop, fire && band_s1, !state_q.stop)
	`BTCL_ASSERT_NEXT(a_stop_zeroes, fire && held_stop, zero_out)

endmodule
